// ===== sv/gcm_pkg.sv =====
package gcm_pkg;

  // field widths
  localparam int GENE_W = 32;
  localparam int FRAC_W = 16;
  localparam int RATE_W = 17;
  localparam int LEN_W  = 11;
  localparam int POS_W  = 10;
  localparam int MODE_W = 3;

  // crossover point math
  localparam int GENE_COUNT_MAX = 1024;
  localparam int DIV3_MUL       = 2731;   // 2731 / 8192 ~ 1/3, exact below 8192
  localparam int DIV3_SHIFT     = 13;
  localparam int DIV3_PROD_W    = 2 * (LEN_W + 1);

  // difference times 17-bit fraction
  localparam int MUL_W = GENE_W + 1 + FRAC_W + 1;

  // register file
  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 5;

  localparam logic [FRAC_W-1:0]        FRAC_HALF = 16'h8000;
  localparam logic signed [GENE_W-1:0] GENE_ONE  = 32'sh0001_0000;

  typedef enum logic [2:0] {
    REG_XOVER_MODE   = 3'd0,
    REG_MUT_MODE     = 3'd1,
    REG_XOVER_RATE   = 3'd2,
    REG_MUT_RATE     = 3'd3,
    REG_LOWER_BOUND  = 3'd4,
    REG_UPPER_BOUND  = 3'd5,
    REG_CHROM_LENGTH = 3'd6,
    REG_BITFLIP_RATE = 3'd7
  } cfg_reg_t;

  typedef enum logic [1:0] {
    XOVER_SINGLE  = 2'd0,
    XOVER_TWO     = 2'd1,
    XOVER_UNIFORM = 2'd2,
    XOVER_BLEND   = 2'd3
  } xover_mode_t;

  typedef enum logic [MODE_W-1:0] {
    MUT_BITSTRING = 3'd0,
    MUT_FLIP      = 3'd1,
    MUT_BOUNDARY  = 3'd2,
    MUT_UNIFORM   = 3'd3,
    MUT_GAUSSIAN  = 3'd4
  } mut_mode_t;

  // reset values
  localparam xover_mode_t        RST_XOVER_MODE   = XOVER_SINGLE;
  localparam logic [MODE_W-1:0]  RST_MUT_MODE     = MUT_UNIFORM;
  localparam logic [RATE_W-1:0]  RST_XOVER_RATE   = 17'd52429;
  localparam logic [RATE_W-1:0]  RST_MUT_RATE     = 17'd6554;
  localparam logic [GENE_W-1:0]  RST_LOWER_BOUND  = 32'd0;
  localparam logic [GENE_W-1:0]  RST_UPPER_BOUND  = 32'd65536;
  localparam logic [LEN_W-1:0]   RST_CHROM_LENGTH = 11'd1;
  localparam logic [RATE_W-1:0]  RST_BITFLIP_RATE = 17'd65536;

  // per-child mutation decisions, made early and carried down the pipe
  typedef struct packed {
    logic active;     // crossover took place
    logic hit_flip;   // draw below bitflip rate
    logic hit_rate;   // draw below mutation rate
    logic side_up;    // boundary mode picks the upper bound
  } mut_ctl_t;

  typedef struct packed {
    logic [MODE_W-1:0]        mode;
    logic signed [GENE_W-1:0] lower;
    logic signed [GENE_W-1:0] upper;
  } mut_cfg_t;

endpackage

// ===== sv/gcm_mutate.sv =====
module gcm_mutate import gcm_pkg::*; (
  input  mut_cfg_t                 cfg,
  input  mut_ctl_t                 ctl,
  input  logic signed [GENE_W-1:0] gene_in,
  input  logic signed [GENE_W-1:0] uni_val,
  input  logic signed [GENE_W-1:0] normal,
  output logic signed [GENE_W-1:0] gene_out,
  output logic                     mutated
);

  logic signed [GENE_W:0]   sum;
  logic signed [GENE_W:0]   lo_x;
  logic signed [GENE_W:0]   up_x;
  logic signed [GENE_W-1:0] not_val;

  always_comb begin
    sum     = {gene_in[GENE_W-1], gene_in} + {normal[GENE_W-1], normal};
    lo_x    = {cfg.lower[GENE_W-1], cfg.lower};
    up_x    = {cfg.upper[GENE_W-1], cfg.upper};
    not_val = (gene_in == '0) ? GENE_ONE : '0;

    gene_out = gene_in;
    mutated  = 1'b0;
    if (ctl.active) begin
      case (cfg.mode)
        MUT_BITSTRING: begin
          if (ctl.hit_flip) begin
            mutated  = 1'b1;
            gene_out = not_val;
          end
        end
        MUT_FLIP: begin
          mutated  = 1'b1;
          gene_out = not_val;
        end
        MUT_BOUNDARY: begin
          if (ctl.hit_rate) begin
            mutated  = 1'b1;
            gene_out = ctl.side_up ? cfg.upper : cfg.lower;
          end
        end
        MUT_UNIFORM: begin
          if (ctl.hit_rate) begin
            mutated  = 1'b1;
            gene_out = uni_val;
          end
        end
        MUT_GAUSSIAN: begin
          if (ctl.hit_rate) begin
            mutated = 1'b1;
            // upper bound wins when the bounds are crossed
            if (sum > up_x) begin
              gene_out = cfg.upper;
            end else if (sum < lo_x) begin
              gene_out = cfg.lower;
            end else begin
              gene_out = sum[GENE_W-1:0];
            end
          end
        end
        default: begin
          gene_out = gene_in;
          mutated  = 1'b0;
        end
      endcase
    end
  end

endmodule

// ===== sv/gene_crossover_mutation_core.sv =====
// pipeline: each input transaction passes the input reg, multiply, crossover/uniform
//   value and mutation/output reg stages on its way to out_valid
// throughput: one transaction per cycle while out_stall is low, set by the fully
//   pipelined multipliers; stall reaches back combinationally, bubbles close up
// reset: synchronous active-low rst_n empties the pipe and loads register defaults
module gene_crossover_mutation_core import gcm_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,

  // register port
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [CFG_ADDR_W-1:0]    paddr,
  input  logic [CFG_DATA_W-1:0]    pwdata,
  output logic [CFG_DATA_W-1:0]    prdata,
  output logic                     pready,

  // input channel
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic signed [GENE_W-1:0] in_parent_a_gene,
  input  logic signed [GENE_W-1:0] in_parent_b_gene,
  input  logic [POS_W-1:0]         in_gene_position,
  input  logic [FRAC_W-1:0]        in_pair_draw,
  input  logic                     in_mask_bit,
  input  logic [FRAC_W-1:0]        in_blend_weight,
  input  logic [FRAC_W-1:0]        in_draw_a,
  input  logic [FRAC_W-1:0]        in_value_draw_a,
  input  logic [FRAC_W-1:0]        in_draw_b,
  input  logic [FRAC_W-1:0]        in_value_draw_b,
  input  logic signed [GENE_W-1:0] in_normal_a,
  input  logic signed [GENE_W-1:0] in_normal_b,

  // result channel
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [GENE_W-1:0] out_child_a_gene,
  output logic signed [GENE_W-1:0] out_child_b_gene,
  output logic                     out_crossed,
  output logic                     out_mutated_a,
  output logic                     out_mutated_b
);

  // ---------------------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------------------
  xover_mode_t              cfg_xover_mode_r;
  logic [MODE_W-1:0]        cfg_mut_mode_r;
  logic [RATE_W-1:0]        cfg_xover_rate_r;
  logic [RATE_W-1:0]        cfg_mut_rate_r;
  logic signed [GENE_W-1:0] cfg_lower_r;
  logic signed [GENE_W-1:0] cfg_upper_r;
  logic [LEN_W-1:0]         cfg_length_r;
  logic [RATE_W-1:0]        cfg_bitflip_rate_r;
  logic signed [GENE_W:0]   cfg_span_r;    // upper - lower, for uniform mutation

  cfg_reg_t                 cfg_idx;
  logic                     cfg_wr;

  assign pready  = 1'b1;
  assign cfg_idx = cfg_reg_t'(paddr[CFG_ADDR_W-1:2]);
  assign cfg_wr  = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_xover_mode_r   <= RST_XOVER_MODE;
      cfg_mut_mode_r     <= RST_MUT_MODE;
      cfg_xover_rate_r   <= RST_XOVER_RATE;
      cfg_mut_rate_r     <= RST_MUT_RATE;
      cfg_lower_r        <= RST_LOWER_BOUND;
      cfg_upper_r        <= RST_UPPER_BOUND;
      cfg_length_r       <= RST_CHROM_LENGTH;
      cfg_bitflip_rate_r <= RST_BITFLIP_RATE;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_XOVER_MODE:   cfg_xover_mode_r   <= xover_mode_t'(pwdata[1:0]);
        REG_MUT_MODE:     cfg_mut_mode_r     <= pwdata[MODE_W-1:0];
        REG_XOVER_RATE:   cfg_xover_rate_r   <= pwdata[RATE_W-1:0];
        REG_MUT_RATE:     cfg_mut_rate_r     <= pwdata[RATE_W-1:0];
        REG_LOWER_BOUND:  cfg_lower_r        <= pwdata[GENE_W-1:0];
        REG_UPPER_BOUND:  cfg_upper_r        <= pwdata[GENE_W-1:0];
        REG_CHROM_LENGTH: cfg_length_r       <= pwdata[LEN_W-1:0];
        REG_BITFLIP_RATE: cfg_bitflip_rate_r <= pwdata[RATE_W-1:0];
        default: ;
      endcase
    end
  end

  // bounds only change while idle is the user's duty; the block does not enforce it. Then
  // the span is settled before any transaction reaches the multiply stage
  always_ff @(posedge clk) begin
    cfg_span_r <= {cfg_upper_r[GENE_W-1], cfg_upper_r}
                - {cfg_lower_r[GENE_W-1], cfg_lower_r};
  end

  always_comb begin
    case (cfg_idx)
      REG_XOVER_MODE:   prdata = CFG_DATA_W'(cfg_xover_mode_r);
      REG_MUT_MODE:     prdata = CFG_DATA_W'(cfg_mut_mode_r);
      REG_XOVER_RATE:   prdata = CFG_DATA_W'(cfg_xover_rate_r);
      REG_MUT_RATE:     prdata = CFG_DATA_W'(cfg_mut_rate_r);
      REG_LOWER_BOUND:  prdata = cfg_lower_r;
      REG_UPPER_BOUND:  prdata = cfg_upper_r;
      REG_CHROM_LENGTH: prdata = CFG_DATA_W'(cfg_length_r);
      REG_BITFLIP_RATE: prdata = CFG_DATA_W'(cfg_bitflip_rate_r);
      default:          prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // pipeline flow control: each stage moves when it is empty or the next moves
  // ---------------------------------------------------------------------------
  logic s1_valid_r, s2_valid_r, s3_valid_r, out_valid_r;
  logic en1, en2, en3, en_out;

  assign en_out   = !out_valid_r || !out_stall;
  assign en3      = !s3_valid_r  || en_out;
  assign en2      = !s2_valid_r  || en3;
  assign en1      = !s1_valid_r  || en2;
  assign in_stall = !en1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      s3_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (en1)    s1_valid_r  <= in_valid;
      if (en2)    s2_valid_r  <= s1_valid_r;
      if (en3)    s3_valid_r  <= s2_valid_r;
      if (en_out) out_valid_r <= s3_valid_r;
    end
  end

  // ---------------------------------------------------------------------------
  // input side: crossover decision, mutation decisions, parent difference
  // ---------------------------------------------------------------------------
  logic [LEN_W-1:0]       len_sat;
  logic [LEN_W-1:0]       len_half;
  logic [DIV3_PROD_W-1:0] third_prod;
  logic [DIV3_PROD_W-1:0] two_third_prod;
  logic [LEN_W-1:0]       len_third;
  logic [LEN_W-1:0]       len_two_third;
  logic [LEN_W-1:0]       pos_x;
  logic                   keep;
  logic                   crossed_in;
  logic                   swap_in;
  logic                   blend_in;
  mut_ctl_t               ctl_a_in;
  mut_ctl_t               ctl_b_in;
  logic signed [GENE_W:0] diff_in;

  always_comb begin
    // length is saturated to the largest supported chromosome
    len_sat = (cfg_length_r > LEN_W'(GENE_COUNT_MAX)) ? LEN_W'(GENE_COUNT_MAX)
                                                      : cfg_length_r;
    len_half = len_sat >> 1;
    // floor of L/3 and 2L/3 by reciprocal multiply
    third_prod     = DIV3_PROD_W'(len_sat) * DIV3_PROD_W'(DIV3_MUL);
    two_third_prod = DIV3_PROD_W'({len_sat, 1'b0}) * DIV3_PROD_W'(DIV3_MUL);
    len_third      = third_prod[DIV3_SHIFT +: LEN_W];
    len_two_third  = two_third_prod[DIV3_SHIFT +: LEN_W];
    pos_x          = {1'b0, in_gene_position};

    case (cfg_xover_mode_r)
      XOVER_SINGLE:  keep = pos_x < len_half;
      XOVER_TWO:     keep = (pos_x < len_third) || (pos_x > len_two_third);
      XOVER_UNIFORM: keep = in_mask_bit;
      XOVER_BLEND:   keep = 1'b1;
      default:       keep = 1'b1;
    endcase

    crossed_in = {1'b0, in_pair_draw} < cfg_xover_rate_r;
    blend_in   = crossed_in && (cfg_xover_mode_r == XOVER_BLEND);
    swap_in    = crossed_in && (cfg_xover_mode_r != XOVER_BLEND) && !keep;

    ctl_a_in.active   = crossed_in;
    ctl_a_in.hit_flip = {1'b0, in_draw_a} < cfg_bitflip_rate_r;
    ctl_a_in.hit_rate = {1'b0, in_draw_a} < cfg_mut_rate_r;
    ctl_a_in.side_up  = in_value_draw_a > FRAC_HALF;

    ctl_b_in.active   = crossed_in;
    ctl_b_in.hit_flip = {1'b0, in_draw_b} < cfg_bitflip_rate_r;
    ctl_b_in.hit_rate = {1'b0, in_draw_b} < cfg_mut_rate_r;
    ctl_b_in.side_up  = in_value_draw_b > FRAC_HALF;

    // blend rewrites as b + d*r and a - d*r with d = a - b
    diff_in = {in_parent_a_gene[GENE_W-1], in_parent_a_gene}
            - {in_parent_b_gene[GENE_W-1], in_parent_b_gene};
  end

  // stage 1 registers
  logic signed [GENE_W-1:0] s1_a_r, s1_b_r, s1_na_r, s1_nb_r;
  logic signed [GENE_W:0]   s1_diff_r;
  logic [FRAC_W-1:0]        s1_w_r, s1_va_r, s1_vb_r;
  logic                     s1_crossed_r, s1_swap_r, s1_blend_r;
  mut_ctl_t                 s1_ctl_a_r, s1_ctl_b_r;

  always_ff @(posedge clk) begin
    if (en1) begin
      s1_a_r       <= in_parent_a_gene;
      s1_b_r       <= in_parent_b_gene;
      s1_na_r      <= in_normal_a;
      s1_nb_r      <= in_normal_b;
      s1_diff_r    <= diff_in;
      s1_w_r       <= in_blend_weight;
      s1_va_r      <= in_value_draw_a;
      s1_vb_r      <= in_value_draw_b;
      s1_crossed_r <= crossed_in;
      s1_swap_r    <= swap_in;
      s1_blend_r   <= blend_in;
      s1_ctl_a_r   <= ctl_a_in;
      s1_ctl_b_r   <= ctl_b_in;
    end
  end

  // ---------------------------------------------------------------------------
  // stage 2: the three 33 x 17 multiplies
  // ---------------------------------------------------------------------------
  logic signed [GENE_W-1:0] s2_a_r, s2_b_r, s2_na_r, s2_nb_r;
  logic signed [MUL_W-1:0]  s2_blend_prod_r, s2_uni_a_prod_r, s2_uni_b_prod_r;
  logic                     s2_crossed_r, s2_swap_r, s2_blend_r;
  mut_ctl_t                 s2_ctl_a_r, s2_ctl_b_r;

  always_ff @(posedge clk) begin
    if (en2) begin
      s2_blend_prod_r <= s1_diff_r  * $signed({1'b0, s1_w_r});
      s2_uni_a_prod_r <= cfg_span_r * $signed({1'b0, s1_va_r});
      s2_uni_b_prod_r <= cfg_span_r * $signed({1'b0, s1_vb_r});
      s2_a_r          <= s1_a_r;
      s2_b_r          <= s1_b_r;
      s2_na_r         <= s1_na_r;
      s2_nb_r         <= s1_nb_r;
      s2_crossed_r    <= s1_crossed_r;
      s2_swap_r       <= s1_swap_r;
      s2_blend_r      <= s1_blend_r;
      s2_ctl_a_r      <= s1_ctl_a_r;
      s2_ctl_b_r      <= s1_ctl_b_r;
    end
  end

  // ---------------------------------------------------------------------------
  // stage 3: round the blend, pick the crossed genes, form uniform values
  // ---------------------------------------------------------------------------
  logic [MUL_W-1:0]         rnd_a, rnd_b;
  logic signed [GENE_W-1:0] blend_a, blend_b, xa, xb, uni_a, uni_b;

  always_comb begin
    // round to nearest, ties up: floor((x + half) / 65536) as an arithmetic shift
    rnd_a   = s2_blend_prod_r + MUL_W'(FRAC_HALF);
    rnd_b   = MUL_W'(FRAC_HALF) - s2_blend_prod_r;
    blend_a = s2_b_r + rnd_a[FRAC_W +: GENE_W];
    blend_b = s2_a_r + rnd_b[FRAC_W +: GENE_W];

    if (s2_blend_r) begin
      xa = blend_a;
      xb = blend_b;
    end else if (s2_swap_r) begin
      xa = s2_b_r;
      xb = s2_a_r;
    end else begin
      xa = s2_a_r;
      xb = s2_b_r;
    end

    // lower + floor(v * span / 65536), kept to the low gene bits
    uni_a = cfg_lower_r + s2_uni_a_prod_r[FRAC_W +: GENE_W];
    uni_b = cfg_lower_r + s2_uni_b_prod_r[FRAC_W +: GENE_W];
  end

  logic signed [GENE_W-1:0] s3_ga_r, s3_gb_r, s3_ua_r, s3_ub_r, s3_na_r, s3_nb_r;
  logic                     s3_crossed_r;
  mut_ctl_t                 s3_ctl_a_r, s3_ctl_b_r;

  always_ff @(posedge clk) begin
    if (en3) begin
      s3_ga_r      <= xa;
      s3_gb_r      <= xb;
      s3_ua_r      <= uni_a;
      s3_ub_r      <= uni_b;
      s3_na_r      <= s2_na_r;
      s3_nb_r      <= s2_nb_r;
      s3_crossed_r <= s2_crossed_r;
      s3_ctl_a_r   <= s2_ctl_a_r;
      s3_ctl_b_r   <= s2_ctl_b_r;
    end
  end

  // ---------------------------------------------------------------------------
  // stage 4: mutation of each child, into the output register
  // ---------------------------------------------------------------------------
  mut_cfg_t                 mut_cfg;
  logic signed [GENE_W-1:0] mut_ga, mut_gb;
  logic                     mut_fa, mut_fb;

  assign mut_cfg.mode  = cfg_mut_mode_r;
  assign mut_cfg.lower = cfg_lower_r;
  assign mut_cfg.upper = cfg_upper_r;

  gcm_mutate u_mutate_a (
    .cfg      (mut_cfg),
    .ctl      (s3_ctl_a_r),
    .gene_in  (s3_ga_r),
    .uni_val  (s3_ua_r),
    .normal   (s3_na_r),
    .gene_out (mut_ga),
    .mutated  (mut_fa)
  );

  gcm_mutate u_mutate_b (
    .cfg      (mut_cfg),
    .ctl      (s3_ctl_b_r),
    .gene_in  (s3_gb_r),
    .uni_val  (s3_ub_r),
    .normal   (s3_nb_r),
    .gene_out (mut_gb),
    .mutated  (mut_fb)
  );

  logic signed [GENE_W-1:0] out_ga_r, out_gb_r;
  logic                     out_crossed_r, out_mut_a_r, out_mut_b_r;

  always_ff @(posedge clk) begin
    if (en_out) begin
      out_ga_r      <= mut_ga;
      out_gb_r      <= mut_gb;
      out_crossed_r <= s3_crossed_r;
      out_mut_a_r   <= mut_fa;
      out_mut_b_r   <= mut_fb;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_child_a_gene = out_ga_r;
  assign out_child_b_gene = out_gb_r;
  assign out_crossed      = out_crossed_r;
  assign out_mutated_a    = out_mut_a_r;
  assign out_mutated_b    = out_mut_b_r;

endmodule

// ===== sv/gcm_port_checker.sv =====
module gcm_port_checker import gcm_pkg::*; (
  input logic                     clk,
  input logic                     rst_n,
  input logic                     in_stall,
  input logic                     out_valid,
  input logic                     out_stall,
  input logic signed [GENE_W-1:0] out_child_a_gene,
  input logic signed [GENE_W-1:0] out_child_b_gene,
  input logic                     out_crossed,
  input logic                     out_mutated_a,
  input logic                     out_mutated_b
);

  // a stalled result stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_child_a_gene) && $stable(out_child_b_gene)
      && $stable(out_crossed) && $stable(out_mutated_a) && $stable(out_mutated_b))
    else $error("result changed while stalled");

  // back pressure only comes from a stalled result
  a_no_false_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !out_stall |-> !in_stall)
    else $error("input stalled while output drains");

  // pass-through pairs are never mutated
  a_pass_unmutated: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_crossed |-> !out_mutated_a && !out_mutated_b)
    else $error("mutation flagged without crossover");

endmodule

bind gene_crossover_mutation_core gcm_port_checker u_gcm_port_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_stall         (in_stall),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_child_a_gene (out_child_a_gene),
  .out_child_b_gene (out_child_b_gene),
  .out_crossed      (out_crossed),
  .out_mutated_a    (out_mutated_a),
  .out_mutated_b    (out_mutated_b)
);
